// ===== design/apbf_pkg.sv =====
// shared types and constants for the address/port blocklist filter
// no dependencies
`default_nettype none

package apbf_pkg;

    typedef enum logic [2:0] {
        ACT_CHECK     = 3'd0,
        ACT_ADD_ADDR  = 3'd1,
        ACT_ADD_SPORT = 3'd2,
        ACT_ADD_DPORT = 3'd3,
        ACT_DEL_ADDR  = 3'd4,
        ACT_DEL_SPORT = 3'd5,
        ACT_DEL_DPORT = 3'd6
    } t_action;

    typedef enum logic [1:0] {
        TS_NONE  = 2'd0,
        TS_ADDR  = 2'd1,
        TS_SPORT = 2'd2,
        TS_DPORT = 2'd3
    } t_tsel;

    localparam logic [1:0] CAUSE_NONE = 2'd0;
    localparam logic [1:0] CAUSE_ADDR = 2'd1;
    localparam logic [1:0] CAUSE_PORT = 2'd2;

    localparam logic [7:0] PROTO_UDP        = 8'd17;
    localparam logic [7:0] PROTO_TCP        = 8'd6;
    localparam logic [3:0] MIN_HEADER_WORDS = 4'd5;
    localparam logic [3:0] IPV4_VERSION     = 4'd4;

    typedef struct packed {
        logic clear;
        logic load;
        logic scan;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic idx_last;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== design/apbf_ram.sv =====
// generic single write port, single registered read port memory
// no dependencies
`default_nettype none

module apbf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/apbf_ctrl.sv =====
// controller state machine: clearing pass, accept, table scan, compare drain, commit
// depends on apbf_pkg
`default_nettype none

module apbf_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire apbf_pkg::t_dp_sts i_sts,
    output apbf_pkg::t_dp_cmd     o_cmd
);

    import apbf_pkg::*;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_in_ready   = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== design/apbf_dp.sv =====
// datapath: item registers, three blocklist memories, scan compare, result register
// depends on apbf_pkg and apbf_ram
`default_nettype none

module apbf_dp #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire apbf_pkg::t_dp_cmd i_cmd,
    output apbf_pkg::t_dp_sts      o_sts,
    input  wire logic [2:0]        i_action,
    input  wire logic              i_direction,
    input  wire logic              i_has_link_header,
    input  wire logic [3:0]        i_ip_version,
    input  wire logic [3:0]        i_header_words,
    input  wire logic [7:0]        i_protocol,
    input  wire logic [31:0]       i_source_address,
    input  wire logic [15:0]       i_source_port,
    input  wire logic [15:0]       i_dest_port,
    input  wire logic [31:0]       i_value,
    input  wire logic              i_out_ready,
    output logic                   o_out_valid,
    output logic                   o_verdict,
    output logic [1:0]             o_drop_cause,
    output logic                   o_status
);

    import apbf_pkg::*;

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    t_action       r_action;
    t_tsel         r_tsel;
    logic          r_dir;
    logic          r_pkt_go;
    logic          r_is_l4;
    logic [31:0]   r_saddr;
    logic [15:0]   r_sport;
    logic [15:0]   r_dport;
    logic [31:0]   r_value;

    logic [IW-1:0] r_idx;
    logic          r_cmp_vld;
    logic [IW-1:0] r_cmp_idx;

    logic          r_addr_hit;
    logic          r_sp_hit;
    logic          r_dp_hit;
    logic          r_found;
    logic [IW-1:0] r_found_idx;
    logic          r_have_empty;
    logic [IW-1:0] r_empty_idx;

    logic          r_out_valid;
    logic          r_verdict;
    logic [1:0]    r_drop_cause;
    logic          r_status;

    logic [31:0]   addr_q;
    logic [15:0]   sp_q;
    logic [15:0]   dp_q;
    logic [31:0]   t_q;

    logic          n_verdict;
    logic [1:0]    n_drop_cause;
    logic          n_status;
    logic          is_add;
    logic          is_del;
    logic          bad_val;
    logic          wr_ok;
    logic [IW-1:0] wr_idx;
    logic [31:0]   wr_data;

    logic          we_addr;
    logic          we_sp;
    logic          we_dp;
    logic [IW-1:0] waddr;
    logic [31:0]   wdata;

    t_action       in_action;
    t_tsel         in_tsel;

    assign in_action = t_action'(i_action);

    always_comb begin
        unique case (in_action)
            ACT_ADD_ADDR, ACT_DEL_ADDR:   in_tsel = TS_ADDR;
            ACT_ADD_SPORT, ACT_DEL_SPORT: in_tsel = TS_SPORT;
            ACT_ADD_DPORT, ACT_DEL_DPORT: in_tsel = TS_DPORT;
            default:                      in_tsel = TS_NONE;
        endcase
    end

    always_comb begin
        unique case (r_tsel)
            TS_ADDR:  t_q = addr_q;
            TS_SPORT: t_q = {16'd0, sp_q};
            TS_DPORT: t_q = {16'd0, dp_q};
            default:  t_q = '0;
        endcase
    end

    always_comb begin
        is_add  = (r_action == ACT_ADD_ADDR) || (r_action == ACT_ADD_SPORT) ||
                  (r_action == ACT_ADD_DPORT);
        is_del  = (r_action == ACT_DEL_ADDR) || (r_action == ACT_DEL_SPORT) ||
                  (r_action == ACT_DEL_DPORT);
        bad_val = (r_value == '0) || ((r_tsel != TS_ADDR) && (r_value[31:16] != '0));
        wr_ok   = (is_add && !bad_val && !r_found && r_have_empty) ||
                  (is_del && !bad_val && r_found);
        wr_idx  = is_add ? r_empty_idx : r_found_idx;
        wr_data = is_add ? r_value : '0;

        n_verdict    = 1'b0;
        n_drop_cause = CAUSE_NONE;
        n_status     = 1'b0;
        unique case (r_action)
            ACT_CHECK: begin
                if (r_pkt_go) begin
                    if (r_addr_hit) begin
                        n_verdict    = 1'b1;
                        n_drop_cause = CAUSE_ADDR;
                    end else if (r_is_l4 && (r_dir ? r_dp_hit : r_sp_hit)) begin
                        n_verdict    = 1'b1;
                        n_drop_cause = CAUSE_PORT;
                    end
                end
            end
            default: begin
                n_status = !wr_ok;
            end
        endcase
    end

    // clearing pass or committed table edit
    always_comb begin
        we_addr = i_cmd.clear || (i_cmd.commit && wr_ok && (r_tsel == TS_ADDR));
        we_sp   = i_cmd.clear || (i_cmd.commit && wr_ok && (r_tsel == TS_SPORT));
        we_dp   = i_cmd.clear || (i_cmd.commit && wr_ok && (r_tsel == TS_DPORT));
        waddr   = i_cmd.clear ? r_idx : wr_idx;
        wdata   = i_cmd.clear ? '0 : wr_data;
    end

    apbf_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH), .AW(IW)) u_ram_addr (
        .i_clk   (i_clk),
        .i_we    (we_addr),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (r_idx),
        .o_rdata (addr_q)
    );

    apbf_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH), .AW(IW)) u_ram_sport (
        .i_clk   (i_clk),
        .i_we    (we_sp),
        .i_waddr (waddr),
        .i_wdata (wdata[15:0]),
        .i_raddr (r_idx),
        .o_rdata (sp_q)
    );

    apbf_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH), .AW(IW)) u_ram_dport (
        .i_clk   (i_clk),
        .i_we    (we_dp),
        .i_waddr (waddr),
        .i_wdata (wdata[15:0]),
        .i_raddr (r_idx),
        .o_rdata (dp_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan;
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.clear || i_cmd.scan) begin
                r_idx <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx;
        if (i_cmd.load) begin
            r_action     <= in_action;
            r_tsel       <= in_tsel;
            r_dir        <= i_direction;
            r_pkt_go     <= i_has_link_header && (i_ip_version == IPV4_VERSION) &&
                            (i_header_words >= MIN_HEADER_WORDS);
            r_is_l4      <= (i_protocol == PROTO_UDP) || (i_protocol == PROTO_TCP);
            r_saddr      <= i_source_address;
            r_sport      <= i_source_port;
            r_dport      <= i_dest_port;
            r_value      <= i_value;
            r_addr_hit   <= 1'b0;
            r_sp_hit     <= 1'b0;
            r_dp_hit     <= 1'b0;
            r_found      <= 1'b0;
            r_found_idx  <= '0;
            r_have_empty <= 1'b0;
            r_empty_idx  <= '0;
        end else if (r_cmp_vld) begin
            if ((r_saddr != '0) && (addr_q == r_saddr)) begin
                r_addr_hit <= 1'b1;
            end
            if ((r_sport != '0) && (sp_q == r_sport)) begin
                r_sp_hit <= 1'b1;
            end
            if ((r_dport != '0) && (dp_q == r_dport)) begin
                r_dp_hit <= 1'b1;
            end
            if (!r_found && (r_value != '0) && (t_q == r_value)) begin
                r_found     <= 1'b1;
                r_found_idx <= r_cmp_idx;
            end
            if (!r_have_empty && (t_q == '0)) begin
                r_have_empty <= 1'b1;
                r_empty_idx  <= r_cmp_idx;
            end
        end
        if (i_cmd.commit) begin
            r_verdict    <= n_verdict;
            r_drop_cause <= n_drop_cause;
            r_status     <= n_status;
        end
    end

    assign o_sts.idx_last = (r_idx == LAST_IDX);
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_verdict      = r_verdict;
    assign o_drop_cause   = r_drop_cause;
    assign o_status       = r_status;

endmodule

`default_nettype wire

// ===== design/address_port_blocklist_filter.sv =====
// top level of the address/port blocklist filter
// depends on apbf_pkg, apbf_ctrl, apbf_dp (which holds apbf_ram)
//
//   channel | handshake                  | payload
//   --------+----------------------------+------------------------------------------
//   in      | i_in_valid / o_in_ready    | action, direction, header fields, value
//   out     | o_out_valid / i_out_ready  | verdict, drop_cause, status
//
// each transaction steps through accept, one memory read per slot
// (all three tables read in parallel on one port each), one compare drain, one commit
// after reset a clearing pass zeroes every table slot, o_in_ready low
// a result waits in the output register; the next transaction is accepted meanwhile
// and only its commit waits for the output register to free up
`default_nettype none

module address_port_blocklist_filter #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [2:0]  i_action,
    input  wire logic        i_direction,
    input  wire logic        i_has_link_header,
    input  wire logic [3:0]  i_ip_version,
    input  wire logic [3:0]  i_header_words,
    input  wire logic [7:0]  i_protocol,
    input  wire logic [31:0] i_source_address,
    input  wire logic [15:0] i_source_port,
    input  wire logic [15:0] i_dest_port,
    input  wire logic [31:0] i_value,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_verdict,
    output logic [1:0]       o_drop_cause,
    output logic             o_status
);

    import apbf_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    apbf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    apbf_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_action          (i_action),
        .i_direction       (i_direction),
        .i_has_link_header (i_has_link_header),
        .i_ip_version      (i_ip_version),
        .i_header_words    (i_header_words),
        .i_protocol        (i_protocol),
        .i_source_address  (i_source_address),
        .i_source_port     (i_source_port),
        .i_dest_port       (i_dest_port),
        .i_value           (i_value),
        .i_out_ready       (i_out_ready),
        .o_out_valid       (o_out_valid),
        .o_verdict         (o_verdict),
        .o_drop_cause      (o_drop_cause),
        .o_status          (o_status)
    );

endmodule

`default_nettype wire

// ===== design/apbf_checker.sv =====
// port-level checks for the address/port blocklist filter, bound to the top level
// depends on address_port_blocklist_filter
`default_nettype none

module apbf_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_verdict,
    input wire logic [1:0]  o_drop_cause,
    input wire logic        o_status
);

    // result holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_verdict) &&
        $stable(o_drop_cause) && $stable(o_status))
        else $error("output transaction changed while stalled");

    // one transaction at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input ready right after an accepted transaction");

    // clearing pass follows reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input ready during clearing pass");

    // drop cause present exactly when dropped, and a drop is never a table result
    a_verdict_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_verdict == (o_drop_cause != 2'd0)) &&
        !(o_verdict && o_status))
        else $error("inconsistent verdict, drop cause and status");

endmodule

bind address_port_blocklist_filter apbf_checker u_apbf_checker (.*);

`default_nettype wire

// ===== tb/blocklist_filter_checker.sv =====
// watches both channels of the address/port blocklist filter and predicts every result
// depends on apbf_pkg; hands its failure and outstanding counts to tb_top
`default_nettype none

module blocklist_filter_checker #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [2:0]  i_action,
    input  wire logic        i_direction,
    input  wire logic        i_has_link_header,
    input  wire logic [3:0]  i_ip_version,
    input  wire logic [3:0]  i_header_words,
    input  wire logic [7:0]  i_protocol,
    input  wire logic [31:0] i_source_address,
    input  wire logic [15:0] i_source_port,
    input  wire logic [15:0] i_dest_port,
    input  wire logic [31:0] i_value,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic        i_verdict,
    input  wire logic [1:0]  i_drop_cause,
    input  wire logic        i_status,
    output int               o_fail_count,
    output int               o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import apbf_pkg::*;

    localparam logic [31:0] PORT_LIMIT = 32'd65535;

    typedef struct packed {
        logic       verdict;
        logic [1:0] cause;
        logic       status;
    } t_outcome;

    logic [31:0] addr_list [TABLE_DEPTH];
    logic [15:0] port_list [2][TABLE_DEPTH];
    t_outcome    awaited_outcomes [$];
    t_outcome    want;
    int          results_seen;

    function automatic logic address_listed(logic [31:0] v);
        if (v == '0) return 1'b0;
        for (int k = 0; k < TABLE_DEPTH; k++)
            if (addr_list[k] == v) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic port_listed(int d, logic [15:0] p);
        if (p == '0) return 1'b0;
        for (int k = 0; k < TABLE_DEPTH; k++)
            if (port_list[d][k] == p) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic add_address(logic [31:0] v);
        if (v == '0 || address_listed(v)) return 1'b1;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (addr_list[k] == '0) begin
                addr_list[k] = v;
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic add_port(int d, logic [31:0] v);
        if (v == '0 || v > PORT_LIMIT || port_listed(d, v[15:0])) return 1'b1;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (port_list[d][k] == '0) begin
                port_list[d][k] = v[15:0];
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic drop_address(logic [31:0] v);
        if (v == '0) return 1'b1;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (addr_list[k] == v) begin
                addr_list[k] = '0;
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic logic drop_port(int d, logic [31:0] v);
        if (v == '0 || v > PORT_LIMIT) return 1'b1;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (port_list[d][k] == v[15:0]) begin
                port_list[d][k] = '0;
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic t_outcome judge_request();
        t_outcome res;
        logic     hit;
        res = '0;
        case (i_action)
            ACT_CHECK: begin
                if (i_has_link_header && i_ip_version == IPV4_VERSION &&
                    i_header_words >= MIN_HEADER_WORDS) begin
                    if (address_listed(i_source_address)) begin
                        res.verdict = 1'b1;
                        res.cause   = CAUSE_ADDR;
                    end else if (i_protocol == PROTO_UDP || i_protocol == PROTO_TCP) begin
                        hit = i_direction ? port_listed(1, i_dest_port)
                                          : port_listed(0, i_source_port);
                        if (hit) begin
                            res.verdict = 1'b1;
                            res.cause   = CAUSE_PORT;
                        end
                    end
                end
            end
            ACT_ADD_ADDR:  res.status = add_address(i_value);
            ACT_ADD_SPORT: res.status = add_port(0, i_value);
            ACT_ADD_DPORT: res.status = add_port(1, i_value);
            ACT_DEL_ADDR:  res.status = drop_address(i_value);
            ACT_DEL_SPORT: res.status = drop_port(0, i_value);
            ACT_DEL_DPORT: res.status = drop_port(1, i_value);
            default:       res.status = 1'b1;
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TABLE_DEPTH; k++) begin
                addr_list[k]    = '0;
                port_list[0][k] = '0;
                port_list[1][k] = '0;
            end
            awaited_outcomes.delete();
            results_seen = 0;
            o_fail_count = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                results_seen++;
                if (awaited_outcomes.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("result %0d arrived with no transaction pending",
                                 results_seen);
                end else begin
                    want = awaited_outcomes.pop_front();
                    if (want.verdict !== i_verdict || want.cause !== i_drop_cause ||
                        want.status !== i_status) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("result %0d: expected %0d %0d %0d, got %0d %0d %0d",
                                     results_seen, want.verdict, want.cause, want.status,
                                     i_verdict, i_drop_cause, i_status);
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                awaited_outcomes.push_back(judge_request());
        end
        o_outstanding = awaited_outcomes.size();
    end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// stimulus and final verdict for the address/port blocklist filter
// depends on apbf_pkg, address_port_blocklist_filter and blocklist_filter_checker
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import apbf_pkg::*;

    localparam int          TABLE_DEPTH = 64;
    localparam int          CYCLE_LIMIT = 1000000;
    localparam int          POOL_SIZE   = 48;
    localparam logic [2:0]  ACT_SPARE   = 3'd7;
    localparam int          TBL_ADDR    = 0;
    localparam int          TBL_SPORT   = 1;
    localparam int          TBL_DPORT   = 2;

    typedef struct packed {
        logic [2:0]  action;
        logic        direction;
        logic        link;
        logic [3:0]  version;
        logic [3:0]  hwords;
        logic [7:0]  proto;
        logic [31:0] saddr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [31:0] value;
    } t_request;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [2:0]  i_action;
    logic        i_direction;
    logic        i_has_link_header;
    logic [3:0]  i_ip_version;
    logic [3:0]  i_header_words;
    logic [7:0]  i_protocol;
    logic [31:0] i_source_address;
    logic [15:0] i_source_port;
    logic [15:0] i_dest_port;
    logic [31:0] i_value;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_verdict;
    logic [1:0]  o_drop_cause;
    logic        o_status;

    int          fail_count;
    int          outstanding;
    int          cycle_count;
    logic        quiet;
    logic [31:0] addr_pool [POOL_SIZE];
    logic [15:0] port_pool [POOL_SIZE];
    logic [31:0] fresh_vals [$];

    address_port_blocklist_filter #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_action          (i_action),
        .i_direction       (i_direction),
        .i_has_link_header (i_has_link_header),
        .i_ip_version      (i_ip_version),
        .i_header_words    (i_header_words),
        .i_protocol        (i_protocol),
        .i_source_address  (i_source_address),
        .i_source_port     (i_source_port),
        .i_dest_port       (i_dest_port),
        .i_value           (i_value),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_verdict         (o_verdict),
        .o_drop_cause      (o_drop_cause),
        .o_status          (o_status)
    );

    blocklist_filter_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_ready        (o_in_ready),
        .i_action          (i_action),
        .i_direction       (i_direction),
        .i_has_link_header (i_has_link_header),
        .i_ip_version      (i_ip_version),
        .i_header_words    (i_header_words),
        .i_protocol        (i_protocol),
        .i_source_address  (i_source_address),
        .i_source_port     (i_source_port),
        .i_dest_port       (i_dest_port),
        .i_value           (i_value),
        .i_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .i_verdict         (o_verdict),
        .i_drop_cause      (o_drop_cause),
        .i_status          (o_status),
        .o_fail_count      (fail_count),
        .o_outstanding     (outstanding)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        i_out_ready <= quiet || ($urandom_range(0, 99) >= 18);
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("address_port_blocklist_filter: mismatch");
        $finish;
    end

    function automatic t_action edit_op(logic del, int tbl);
        case (tbl)
            TBL_ADDR:  return del ? ACT_DEL_ADDR : ACT_ADD_ADDR;
            TBL_SPORT: return del ? ACT_DEL_SPORT : ACT_ADD_SPORT;
            default:   return del ? ACT_DEL_DPORT : ACT_ADD_DPORT;
        endcase
    endfunction

    function automatic t_request noise_request();
        t_request rq;
        rq.action    = ACT_CHECK;
        rq.direction = 1'($urandom_range(0, 1));
        rq.link      = 1'($urandom_range(0, 1));
        rq.version   = 4'($urandom_range(0, 15));
        rq.hwords    = 4'($urandom_range(0, 15));
        rq.proto     = 8'($urandom_range(0, 255));
        rq.saddr     = $urandom;
        rq.sport     = 16'($urandom_range(0, 65535));
        rq.dport     = 16'($urandom_range(0, 65535));
        rq.value     = $urandom;
        return rq;
    endfunction

    function automatic t_request make_edit(logic [2:0] act, logic [31:0] v);
        t_request rq;
        rq        = noise_request();
        rq.action = act;
        rq.value  = v;
        return rq;
    endfunction

    function automatic t_request make_check(logic dir, logic link, logic [3:0] ver,
                                            logic [3:0] hw, logic [7:0] proto,
                                            logic [31:0] saddr, logic [15:0] sport,
                                            logic [15:0] dport);
        t_request rq;
        rq           = noise_request();
        rq.direction = dir;
        rq.link      = link;
        rq.version   = ver;
        rq.hwords    = hw;
        rq.proto     = proto;
        rq.saddr     = saddr;
        rq.sport     = sport;
        rq.dport     = dport;
        return rq;
    endfunction

    function automatic logic [15:0] pick_port();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return port_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r == 5) return '0;
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic t_request random_packet();
        t_request rq;
        int       r;
        rq      = noise_request();
        rq.link = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 6) != 0) rq.version = IPV4_VERSION;
        if ($urandom_range(0, 6) != 0) rq.hwords = 4'($urandom_range(5, 15));
        r = $urandom_range(0, 9);
        if (r < 4) rq.proto = PROTO_UDP;
        else if (r < 8) rq.proto = PROTO_TCP;
        r = $urandom_range(0, 9);
        if (r < 4) rq.saddr = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (r == 4) rq.saddr = '0;
        rq.sport = pick_port();
        rq.dport = pick_port();
        return rq;
    endfunction

    function automatic logic [31:0] pool_value(int tbl);
        if (tbl == TBL_ADDR) return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
        return {16'd0, port_pool[$urandom_range(0, POOL_SIZE - 1)]};
    endfunction

    function automatic logic [31:0] edit_value(int tbl);
        int r;
        r = $urandom_range(0, 9);
        if (r < 7) return pool_value(tbl);
        if (r == 7) return '0;
        if (r == 8 || tbl == TBL_ADDR) return $urandom;
        return 32'($urandom_range(1, 65535));
    endfunction

    function automatic logic [31:0] fresh_value(int tbl);
        if (tbl == TBL_ADDR) return $urandom;
        return 32'($urandom_range(1, 65535));
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic deliver(t_request rq);
        if (!quiet && $urandom_range(0, 99) < 18) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, TABLE_DEPTH + 8)) @(negedge i_clk);
        end
        i_action          <= rq.action;
        i_direction       <= rq.direction;
        i_has_link_header <= rq.link;
        i_ip_version      <= rq.version;
        i_header_words    <= rq.hwords;
        i_protocol        <= rq.proto;
        i_source_address  <= rq.saddr;
        i_source_port     <= rq.sport;
        i_dest_port       <= rq.dport;
        i_value           <= rq.value;
        i_in_valid        <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        @(negedge i_clk);
    endtask

    task automatic await_idle();
        i_in_valid <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
    endtask

    task automatic run_mix(int count, int add_pct, int del_pct);
        int r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < add_pct) begin
                r = $urandom_range(TBL_ADDR, TBL_DPORT);
                deliver(make_edit(edit_op(1'b0, r), edit_value(r)));
            end else if (r < add_pct + del_pct) begin
                r = $urandom_range(TBL_ADDR, TBL_DPORT);
                deliver(make_edit(edit_op(1'b1, r), edit_value(r)));
            end else if (r < add_pct + del_pct + 2) begin
                deliver(make_edit(ACT_SPARE, $urandom));
            end else begin
                deliver(random_packet());
            end
        end
    endtask

    // pushes one table past full, remembering what went in
    task automatic fill_table(int tbl);
        int          adds;
        logic [31:0] v;
        adds = 0;
        fresh_vals.delete();
        while (adds < 80) begin
            if ($urandom_range(0, 3) == 0) begin
                deliver(random_packet());
            end else begin
                v = ($urandom_range(0, 9) < 7) ? fresh_value(tbl) : pool_value(tbl);
                fresh_vals.push_back(v);
                deliver(make_edit(edit_op(1'b0, tbl), v));
                adds++;
            end
        end
    endtask

    task automatic clear_table(int tbl);
        int          k;
        logic [31:0] v;
        while (fresh_vals.size() > 0) begin
            if ($urandom_range(0, 3) == 0) begin
                deliver(random_packet());
            end else begin
                k = $urandom_range(0, fresh_vals.size() - 1);
                v = fresh_vals[k];
                fresh_vals.delete(k);
                deliver(make_edit(edit_op(1'b1, tbl), v));
            end
        end
    endtask

    initial begin
        quiet             = 1'b0;
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_action          = ACT_CHECK;
        i_direction       = 1'b0;
        i_has_link_header = 1'b0;
        i_ip_version      = '0;
        i_header_words    = '0;
        i_protocol        = '0;
        i_source_address  = '0;
        i_source_port     = '0;
        i_dest_port       = '0;
        i_value           = '0;
        for (int k = 0; k < POOL_SIZE; k++) begin
            addr_pool[k] = $urandom;
            if (addr_pool[k] == '0) addr_pool[k] = 32'(k + 1);
            port_pool[k] = 16'($urandom_range(1, 65535));
        end
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // empty tables, extreme fields
        deliver(make_check(1'b0, 1'b1, IPV4_VERSION, 4'd15, PROTO_UDP,
                           32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF));
        deliver(make_edit(ACT_ADD_ADDR, 32'd0));
        deliver(make_edit(ACT_ADD_ADDR, 32'hFFFF_FFFF));
        deliver(make_edit(ACT_ADD_ADDR, 32'hFFFF_FFFF));
        deliver(make_edit(ACT_ADD_SPORT, 32'h0001_0000));
        deliver(make_edit(ACT_ADD_SPORT, 32'd65535));
        deliver(make_edit(ACT_ADD_DPORT, 32'd1));
        deliver(make_edit(ACT_ADD_DPORT, 32'd0));
        // listed address, listed ports, protocol and header bypasses
        deliver(make_check(1'b0, 1'b1, IPV4_VERSION, 4'd5, PROTO_UDP,
                           32'hFFFF_FFFF, 16'd3, 16'd3));
        deliver(make_check(1'b0, 1'b1, IPV4_VERSION, 4'd5, PROTO_TCP,
                           32'd1, 16'hFFFF, 16'd1));
        deliver(make_check(1'b1, 1'b1, IPV4_VERSION, 4'd9, PROTO_TCP,
                           32'd1, 16'hFFFF, 16'd1));
        deliver(make_check(1'b1, 1'b1, IPV4_VERSION, 4'd9, 8'd1,
                           32'd1, 16'hFFFF, 16'd1));
        deliver(make_check(1'b1, 1'b0, IPV4_VERSION, 4'd5, PROTO_UDP,
                           32'hFFFF_FFFF, 16'hFFFF, 16'd1));
        deliver(make_check(1'b0, 1'b1, 4'd6, 4'd5, PROTO_UDP,
                           32'hFFFF_FFFF, 16'hFFFF, 16'd1));
        deliver(make_check(1'b0, 1'b1, IPV4_VERSION, 4'd4, PROTO_UDP,
                           32'hFFFF_FFFF, 16'hFFFF, 16'd1));
        deliver(make_check(1'b0, 1'b1, IPV4_VERSION, 4'd0, PROTO_TCP,
                           32'd7, 16'hFFFF, 16'd1));
        deliver(make_check(1'b0, 1'b1, IPV4_VERSION, 4'd5, PROTO_UDP,
                           32'd0, 16'd0, 16'd0));
        deliver(make_edit(ACT_DEL_ADDR, 32'hFFFF_FFFF));
        deliver(make_edit(ACT_DEL_ADDR, 32'hFFFF_FFFF));
        deliver(make_edit(ACT_DEL_SPORT, 32'h0001_FFFF));
        deliver(make_edit(ACT_DEL_SPORT, 32'd65535));
        deliver(make_edit(ACT_DEL_DPORT, 32'd0));
        deliver(make_edit(ACT_DEL_DPORT, 32'd1));
        deliver(make_edit(ACT_SPARE, 32'hFFFF_FFFF));
        await_idle();

        for (int tbl = TBL_ADDR; tbl <= TBL_DPORT; tbl++) begin
            quiet = (tbl == TBL_SPORT);
            run_mix(110, 20, 15);
            quiet = 1'b0;
            fill_table(tbl);
            run_mix(60, 30, 5);
            clear_table(tbl);
            await_idle();
        end

        await_idle();
        repeat (TABLE_DEPTH + 8) @(posedge i_clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("address_port_blocklist_filter: match");
        end else begin
            $display("address_port_blocklist_filter: mismatch");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
design/apbf_pkg.sv
design/apbf_ram.sv
design/apbf_ctrl.sv
design/apbf_dp.sv
design/address_port_blocklist_filter.sv
design/apbf_checker.sv
tb/blocklist_filter_checker.sv
tb/tb_top.sv
